// ===== rtl/sva_pkg.sv =====
`timescale 1ns / 1ps
package sva_pkg;

  localparam int unsigned VecBits = 64;
  localparam int unsigned NumB = VecBits / 8;
  localparam int unsigned NumH = VecBits / 16;
  localparam int unsigned NumW = VecBits / 32;
  localparam int unsigned NumD = VecBits / 64;

  localparam logic [5:0] OpAdd    = 6'd0;
  localparam logic [5:0] OpSub    = 6'd1;
  localparam logic [5:0] OpRsub   = 6'd2;
  localparam logic [5:0] OpMul    = 6'd3;
  localparam logic [5:0] OpMulh   = 6'd4;
  localparam logic [5:0] OpMulhu  = 6'd5;
  localparam logic [5:0] OpMulhsu = 6'd6;
  localparam logic [5:0] OpMacc   = 6'd7;
  localparam logic [5:0] OpNmsac  = 6'd8;
  localparam logic [5:0] OpMadd   = 6'd9;
  localparam logic [5:0] OpNmsub  = 6'd10;
  localparam logic [5:0] OpAnd    = 6'd11;
  localparam logic [5:0] OpOr     = 6'd12;
  localparam logic [5:0] OpXor    = 6'd13;
  localparam logic [5:0] OpSll    = 6'd14;
  localparam logic [5:0] OpSrl    = 6'd15;
  localparam logic [5:0] OpSra    = 6'd16;
  localparam logic [5:0] OpMinu   = 6'd17;
  localparam logic [5:0] OpMin    = 6'd18;
  localparam logic [5:0] OpMaxu   = 6'd19;
  localparam logic [5:0] OpMax    = 6'd20;
  localparam logic [5:0] OpSaddu  = 6'd21;
  localparam logic [5:0] OpSadd   = 6'd22;
  localparam logic [5:0] OpSsubu  = 6'd23;
  localparam logic [5:0] OpSsub   = 6'd24;
  localparam logic [5:0] OpCmpEq  = 6'd25;
  localparam logic [5:0] OpCmpNe  = 6'd26;
  localparam logic [5:0] OpCmpLt  = 6'd27;
  localparam logic [5:0] OpCmpLtu = 6'd28;
  localparam logic [5:0] OpCmpLe  = 6'd29;
  localparam logic [5:0] OpCmpLeu = 6'd30;
  localparam logic [5:0] OpCmpGt  = 6'd31;
  localparam logic [5:0] OpCmpGtu = 6'd32;
  localparam logic [5:0] OpRedSum = 6'd33;
  localparam logic [5:0] OpRedAnd = 6'd34;
  localparam logic [5:0] OpRedOr  = 6'd35;
  localparam logic [5:0] OpRedXor = 6'd36;
  localparam logic [5:0] OpRedMinu = 6'd37;
  localparam logic [5:0] OpRedMin = 6'd38;
  localparam logic [5:0] OpRedMaxu = 6'd39;
  localparam logic [5:0] OpRedMax = 6'd40;
  localparam logic [5:0] OpWmacc  = 6'd41;
  localparam logic [5:0] OpWmul   = 6'd42;
  localparam logic [5:0] OpWmulu  = 6'd43;
  localparam logic [5:0] OpWmulsu = 6'd44;
  localparam logic [5:0] OpWadd   = 6'd45;
  localparam logic [5:0] OpWaddu  = 6'd46;
  localparam logic [5:0] OpWsub   = 6'd47;
  localparam logic [5:0] OpWsubu  = 6'd48;
  localparam logic [5:0] OpSlideUp = 6'd49;
  localparam logic [5:0] OpSlideDn = 6'd50;
  localparam logic [5:0] OpMove   = 6'd51;
  localparam logic [5:0] OpMerge  = 6'd52;

  // per-lane work decoded from one 32-bit lane view
  typedef struct packed {
    logic [5:0] mode;
    logic [1:0] es;
    logic       unm;
  } ctl_t;

endpackage

// ===== rtl/sva_lane.sv =====
`timescale 1ns / 1ps
// One 32-bit slice: the multiplier products for its sub-elements, part of a three-stage pipe.
// Stage 1 operands and stage 3 are registered in the top, stage 2 products in here.
module sva_lane (
  input  logic        clk_i,
  input  logic        en1_i,
  input  logic [1:0]  es_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic        sa_i,
  input  logic        sb_i,
  output logic [63:0] p8_0_o,
  output logic [63:0] p16_o,
  output logic [63:0] p32_o
);
  // signed products (9x9, 17x17, 33x33); lane holds 4 byte, 2 half, 1 word product
  logic signed [17:0] p8_q [4];
  logic signed [33:0] p16_q [2];
  logic signed [65:0] p32_q;
  logic [3:0][8:0]   a8, b8;
  logic [1:0][16:0]  a16, b16;
  logic [32:0]       a32, b32;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a8[k] = {sa_i & a_i[8*k+7], a_i[8*k +: 8]};
      b8[k] = {sb_i & b_i[8*k+7], b_i[8*k +: 8]};
    end
    for (int k = 0; k < 2; k++) begin
      a16[k] = {sa_i & a_i[16*k+15], a_i[16*k +: 16]};
      b16[k] = {sb_i & b_i[16*k+15], b_i[16*k +: 16]};
    end
    a32 = {sa_i & a_i[31], a_i};
    b32 = {sb_i & b_i[31], b_i};
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      for (int k = 0; k < 4; k++) p8_q[k] <= $signed(a8[k]) * $signed(b8[k]);
      for (int k = 0; k < 2; k++) p16_q[k] <= $signed(a16[k]) * $signed(b16[k]);
      p32_q <= $signed(a32) * $signed(b32);
    end
  end

  assign p8_0_o = {p8_q[3][15:0], p8_q[2][15:0], p8_q[1][15:0], p8_q[0][15:0]};
  assign p16_o  = {p16_q[1][31:0], p16_q[0][31:0]};
  assign p32_o  = (es_i == 2'd3) ? p32_q[63:0] : p32_q[63:0];
endmodule

// ===== rtl/simd_vector_alu.sv =====
`timescale 1ns / 1ps
// simd_vector_alu: packed-SIMD integer vector ALU on a 64-bit vector.
// Usage:
//   Drive mode_i, elem_size_i, the vectors, mask and scalar with start high.
//   A beat is taken on every edge where start is high and busy is low;
//   busy is always low here, so one beat can enter every cycle.
//   The result beat appears on result_o with done_o high for exactly one
//   cycle, after its start beat has passed the stages in order (stage 1: operand setup and
//   broadcast, stage 2: per-lane multipliers and simple element ops,
//   stage 3: accumulate, mask merge and the result register).
//   Throughput: one instruction per cycle.
//   Results come out in the order of their start beats.
//   Reset drops every beat in flight and clears the valid bits.
//   The receiver cannot stall, so nothing holds the pipe.
module simd_vector_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  mode_i,
  input  logic [1:0]  elem_size_i,
  input  logic [63:0] vec_a_i,
  input  logic [63:0] vec_b_i,
  input  logic [63:0] vec_old_i,
  input  logic [7:0]  mask_bits_i,
  input  logic        unmasked_i,
  input  logic        use_scalar_i,
  input  logic [31:0] scalar_i,
  output logic        done_o,
  output logic [63:0] result_o
);

  assign busy = 1'b0;

  // ---------------- stage 1: operand setup ----------------
  logic        v1_q, v2_q, v3_q;
  logic [5:0]  mode1_q, mode2_q;
  logic [1:0]  es1_q, es2_q;
  logic [63:0] a1_q, b1_q, o1_q, a2_q, b2_q, o2_q;
  logic [7:0]  m1_q, m2_q;
  logic        unm1_q, unm2_q;
  logic [31:0] sc1_q;
  logic [63:0] r2_q;       // non-multiply result, already final; element ops are already masked
  logic        use_mul2_q;
  logic [63:0] res3_q;
  logic [63:0] bvec_d;
  logic [1:0]  es_d;

  always_comb begin
    es_d = (elem_size_i == 2'd3) ? 2'd2 : elem_size_i;
    bvec_d = vec_b_i;
    if (use_scalar_i) begin
      case (es_d)
        2'd0:    bvec_d = {8{scalar_i[7:0]}};
        2'd1:    bvec_d = {4{scalar_i[15:0]}};
        default: bvec_d = {2{scalar_i}};
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start & ~busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      mode1_q <= mode_i;
      es1_q   <= es_d;
      a1_q    <= vec_a_i;
      b1_q    <= bvec_d;
      o1_q    <= vec_old_i;
      m1_q    <= mask_bits_i;
      unm1_q  <= unmasked_i;
      sc1_q   <= scalar_i;
    end
  end

  // ---------------- multipliers (stage 1 -> 2) ----------------
  // operand choice: madd/nmsub multiply b*d; widening ops use low half, spread
  logic        sa_d, sb_d;
  logic [63:0] ma_d, mb_d;
  logic        wide1;
  always_comb begin
    wide1 = (mode1_q >= sva_pkg::OpWmacc) && (mode1_q <= sva_pkg::OpWsubu);
    sa_d = (mode1_q == sva_pkg::OpMulh) || (mode1_q == sva_pkg::OpMulhsu) ||
           (mode1_q == sva_pkg::OpWmacc) || (mode1_q == sva_pkg::OpWmul) ||
           (mode1_q == sva_pkg::OpWmulsu);
    sb_d = (mode1_q == sva_pkg::OpMulh) || (mode1_q == sva_pkg::OpWmacc) ||
           (mode1_q == sva_pkg::OpWmul);
    ma_d = a1_q;
    mb_d = b1_q;
    if ((mode1_q == sva_pkg::OpMadd) || (mode1_q == sva_pkg::OpNmsub)) ma_d = o1_q;
    if (wide1) begin
      // spread low elements so element i sits in the slot of wide element i
      case (es1_q)
        2'd0: begin
          for (int k = 0; k < 4; k++) begin
            ma_d[16*k +: 16] = {8'd0, a1_q[8*k +: 8]};
            mb_d[16*k +: 16] = {8'd0, b1_q[8*k +: 8]};
          end
        end
        2'd1: begin
          for (int k = 0; k < 2; k++) begin
            ma_d[32*k +: 32] = {16'd0, a1_q[16*k +: 16]};
            mb_d[32*k +: 32] = {16'd0, b1_q[16*k +: 16]};
          end
        end
        default: begin
          ma_d = a1_q;
          mb_d = b1_q;
        end
      endcase
    end
  end

  // widening multiplies at width w read operands at w from the spread slots,
  // so the lane multiplies at the narrow size using the low half of each slot
  logic [63:0] p8_lo, p8_hi, p16_lo, p16_hi, p32_lo, p32_hi;
  logic [63:0] wa_d, wb_d;
  always_comb begin
    wa_d = ma_d;
    wb_d = mb_d;
    if (wide1) begin
      // narrow elements stay in the low half of their wide slots:
      // the element in wide slot k is multiplied as narrow element 2k
      wa_d = ma_d;
      wb_d = mb_d;
    end
  end

  sva_lane u_lane_lo (
    .clk_i(clk_i), .en1_i(v1_q), .es_i(es1_q),
    .a_i(wa_d[31:0]), .b_i(wb_d[31:0]), .sa_i(sa_d), .sb_i(sb_d),
    .p8_0_o(p8_lo), .p16_o(p16_lo), .p32_o(p32_lo)
  );
  sva_lane u_lane_hi (
    .clk_i(clk_i), .en1_i(v1_q), .es_i(es1_q),
    .a_i(wa_d[63:32]), .b_i(wb_d[63:32]), .sa_i(sa_d), .sb_i(sb_d),
    .p8_0_o(p8_hi), .p16_o(p16_hi), .p32_o(p32_hi)
  );

  // ---------------- simple ops (stage 1 -> 2) ----------------
  function automatic logic [31:0] sext(input logic [31:0] x, input logic [1:0] es);
    case (es)
      2'd0:    sext = {{24{x[7]}}, x[7:0]};
      2'd1:    sext = {{16{x[15]}}, x[15:0]};
      default: sext = x;
    endcase
  endfunction

  function automatic logic [31:0] emask(input logic [1:0] es);
    case (es)
      2'd0:    emask = 32'h0000_00ff;
      2'd1:    emask = 32'h0000_ffff;
      default: emask = 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic [31:0] elem_fn(input logic [5:0] md, input logic [31:0] x,
                                          input logic [31:0] y, input logic [1:0] es);
    logic [31:0] m, sx_x, sx_y, smax, smin, sh;
    logic [32:0] s33, d33;
    logic signed [33:0] ss, sd;
    logic [4:0]  amt;
    logic [31:0] r;
    m = emask(es);
    sx_x = sext(x, es);
    sx_y = sext(y, es);
    amt = y[4:0] & ((es == 2'd0) ? 5'd7 : (es == 2'd1) ? 5'd15 : 5'd31);
    smax = m >> 1;
    smin = ~smax;
    s33 = {1'b0, x} + {1'b0, y};
    d33 = {1'b0, x} - {1'b0, y};
    ss = $signed({{2{sx_x[31]}}, sx_x}) + $signed({{2{sx_y[31]}}, sx_y});
    sd = $signed({{2{sx_x[31]}}, sx_x}) - $signed({{2{sx_y[31]}}, sx_y});
    sh = $signed(sx_x) >>> amt;
    r = 32'd0;
    case (md)
      sva_pkg::OpAdd:  r = x + y;
      sva_pkg::OpSub:  r = x - y;
      sva_pkg::OpRsub: r = y - x;
      sva_pkg::OpAnd:  r = x & y;
      sva_pkg::OpOr:   r = x | y;
      sva_pkg::OpXor:  r = x ^ y;
      sva_pkg::OpSll:  r = x << amt;
      sva_pkg::OpSrl:  r = x >> amt;
      sva_pkg::OpSra:  r = sh;
      sva_pkg::OpMinu: r = (x < y) ? x : y;
      sva_pkg::OpMin:  r = ($signed(sx_x) < $signed(sx_y)) ? x : y;
      sva_pkg::OpMaxu: r = (x > y) ? x : y;
      sva_pkg::OpMax:  r = ($signed(sx_x) > $signed(sx_y)) ? x : y;
      sva_pkg::OpSaddu: r = (s33 > {1'b0, m}) ? m : s33[31:0];
      sva_pkg::OpSadd: r = (ss > $signed({2'b00, smax})) ? smax :
                           (ss < $signed({2'b11, smin})) ? smin : ss[31:0];
      sva_pkg::OpSsubu: r = d33[32] ? 32'd0 : d33[31:0];
      sva_pkg::OpSsub: r = (sd > $signed({2'b00, smax})) ? smax :
                           (sd < $signed({2'b11, smin})) ? smin : sd[31:0];
      sva_pkg::OpMove, sva_pkg::OpMerge: r = y;
      default: r = 32'd0;
    endcase
    elem_fn = r & m;
  endfunction

  function automatic logic cmp_fn(input logic [5:0] md, input logic [31:0] x,
                                  input logic [31:0] y, input logic [1:0] es);
    logic signed [31:0] sx_x, sx_y;
    logic b;
    sx_x = sext(x, es);
    sx_y = sext(y, es);
    case (md)
      sva_pkg::OpCmpEq:  b = x == y;
      sva_pkg::OpCmpNe:  b = x != y;
      sva_pkg::OpCmpLt:  b = sx_x < sx_y;
      sva_pkg::OpCmpLtu: b = x < y;
      sva_pkg::OpCmpLe:  b = sx_x <= sx_y;
      sva_pkg::OpCmpLeu: b = x <= y;
      sva_pkg::OpCmpGt:  b = sx_x > sx_y;
      default:           b = x > y;
    endcase
    cmp_fn = b;
  endfunction

  function automatic logic [31:0] red_fn(input logic [5:0] md, input logic [31:0] acc,
                                         input logic [31:0] x, input logic [1:0] es);
    logic signed [31:0] sa, sx_x;
    logic [31:0] r;
    sa = sext(acc, es);
    sx_x = sext(x, es);
    case (md)
      sva_pkg::OpRedSum:  r = acc + x;
      sva_pkg::OpRedAnd:  r = acc & x;
      sva_pkg::OpRedOr:   r = acc | x;
      sva_pkg::OpRedXor:  r = acc ^ x;
      sva_pkg::OpRedMinu: r = (x < acc) ? x : acc;
      sva_pkg::OpRedMin:  r = (sx_x < sa) ? x : acc;
      sva_pkg::OpRedMaxu: r = (x > acc) ? x : acc;
      default:            r = (sx_x > sa) ? x : acc;
    endcase
    red_fn = r & emask(es);
  endfunction

  // neutral value of a reduction, fills the tree slots past the last element
  function automatic logic [31:0] red_id(input logic [5:0] md, input logic [1:0] es);
    logic [31:0] m;
    m = emask(es);
    case (md)
      sva_pkg::OpRedAnd, sva_pkg::OpRedMinu: red_id = m;
      sva_pkg::OpRedMin:                     red_id = m >> 1;
      sva_pkg::OpRedMax:                     red_id = m & ~(m >> 1);
      default:                               red_id = 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] getel(input logic [63:0] v, input int unsigned i,
                                        input logic [1:0] es);
    case (es)
      2'd0:    getel = {24'd0, v[8*(i%8) +: 8]};
      2'd1:    getel = {16'd0, v[16*(i%4) +: 16]};
      default: getel = v[32*(i%2) +: 32];
    endcase
  endfunction

  logic [63:0] simple_d;
  logic        use_mul_d;
  logic [3:0]  n_el;
  logic [7:0]  cbits;
  logic [31:0] racc;
  logic [7:0][31:0] rv;
  logic [3:0][31:0] rl1;
  logic [1:0][31:0] rl2;
  logic [31:0] rx;
  logic [31:0] ro;
  logic        wr;
  logic signed [32:0] src;
  logic [63:0] elres;

  always_comb begin
    n_el = (es1_q == 2'd0) ? 4'd8 : (es1_q == 2'd1) ? 4'd4 : 4'd2;
    use_mul_d = ((mode1_q >= sva_pkg::OpMul) && (mode1_q <= sva_pkg::OpNmsub)) ||
                ((mode1_q >= sva_pkg::OpWmacc) && (mode1_q <= sva_pkg::OpWsubu));
    cbits = 8'd0;
    elres = 64'd0;
    simple_d = 64'd0;
    rx = 32'd0;
    ro = 32'd0;
    wr = 1'b0;
    src = '0;
    for (int unsigned i = 0; i < 8; i++) begin
      if (i < n_el) cbits[i] = cmp_fn(mode1_q, getel(a1_q, i, es1_q), getel(b1_q, i, es1_q),
                                      es1_q);
    end
    // fold as a pairwise tree, then merge with element 0 of operand B
    for (int unsigned i = 0; i < 8; i++) begin
      rv[i] = (i < n_el) ? getel(a1_q, i, es1_q) : red_id(mode1_q, es1_q);
    end
    for (int unsigned i = 0; i < 4; i++) rl1[i] = red_fn(mode1_q, rv[2*i], rv[2*i+1], es1_q);
    for (int unsigned i = 0; i < 2; i++) rl2[i] = red_fn(mode1_q, rl1[2*i], rl1[2*i+1], es1_q);
    racc = red_fn(mode1_q, getel(b1_q, 0, es1_q), red_fn(mode1_q, rl2[0], rl2[1], es1_q),
                  es1_q);
    for (int unsigned i = 0; i < 8; i++) begin
      if (i < n_el) begin
        ro = getel(o1_q, i, es1_q);
        if ((mode1_q == sva_pkg::OpSlideUp) || (mode1_q == sva_pkg::OpSlideDn)) begin
          src = (mode1_q == sva_pkg::OpSlideUp) ?
                $signed({1'b0, 32'(i)}) - $signed({sc1_q[31], sc1_q}) :
                $signed({1'b0, 32'(i)}) + $signed({sc1_q[31], sc1_q});
          rx = ((src >= 0) && (src < $signed({29'd0, n_el}))) ?
               getel(a1_q, 32'(src[2:0]), es1_q) : ro;
        end else begin
          rx = elem_fn(mode1_q, getel(a1_q, i, es1_q), getel(b1_q, i, es1_q), es1_q);
        end
        wr = unm1_q | m1_q[i];
        if (!wr) rx = (mode1_q == sva_pkg::OpMerge) ? getel(a1_q, i, es1_q) : ro;
        case (es1_q)
          2'd0:    elres[8*(i%8) +: 8] = rx[7:0];
          2'd1:    elres[16*(i%4) +: 16] = rx[15:0];
          default: elres[32*(i%2) +: 32] = rx;
        endcase
      end
    end
    if ((mode1_q >= sva_pkg::OpCmpEq) && (mode1_q <= sva_pkg::OpCmpGtu))
      simple_d = {56'd0, cbits};
    else if ((mode1_q >= sva_pkg::OpRedSum) && (mode1_q <= sva_pkg::OpRedMax))
      simple_d = {32'd0, racc};
    else
      simple_d = elres;
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      mode2_q <= mode1_q;
      es2_q   <= es1_q;
      a2_q    <= a1_q;
      b2_q    <= b1_q;
      o2_q    <= o1_q;
      m2_q    <= m1_q;
      unm2_q  <= unm1_q;
      r2_q    <= simple_d;
      use_mul2_q <= use_mul_d;
    end
  end

  // ---------------- stage 3: accumulate and mask ----------------
  logic [63:0] prod;
  logic [63:0] mres;
  logic [63:0] full;
  always_comb begin
    mres = 64'd0;
    prod = 64'd0;
    full = 64'd0;
    case (es2_q)
      2'd0: begin
        for (int k = 0; k < 8; k++) begin
          full[8*k +: 8] = 8'd0;
        end
        for (int unsigned i = 0; i < 8; i++) begin
          logic [15:0] p;
          logic [7:0]  x, y, d, r8;
          logic [15:0] wide, wo, wr16;
          wide = 16'd0;
          wo = 16'd0;
          wr16 = 16'd0;
          p = (i < 4) ? p8_lo[16*i +: 16] : p8_hi[16*(i-4) +: 16];
          x = a2_q[8*i +: 8];
          y = b2_q[8*i +: 8];
          d = o2_q[8*i +: 8];
          case (mode2_q)
            sva_pkg::OpMul:    r8 = p[7:0];
            sva_pkg::OpMulh, sva_pkg::OpMulhu, sva_pkg::OpMulhsu: r8 = p[15:8];
            sva_pkg::OpMacc:   r8 = d + p[7:0];
            sva_pkg::OpNmsac:  r8 = d - p[7:0];
            sva_pkg::OpMadd:   r8 = p[7:0] + x;
            default:           r8 = x - p[7:0];
          endcase
          if (!(unm2_q | m2_q[i])) r8 = d;
          mres[8*i +: 8] = r8;
          if (i < 4) begin
            wo = o2_q[16*i +: 16];
            prod[16*i +: 16] = (i < 2) ? p8_lo[32*i +: 16] : p8_hi[32*(i-2) +: 16];
            wide = prod[16*i +: 16];
            case (mode2_q)
              sva_pkg::OpWmacc: wr16 = wo + wide;
              sva_pkg::OpWmul, sva_pkg::OpWmulu, sva_pkg::OpWmulsu: wr16 = wide;
              sva_pkg::OpWadd:  wr16 = {{8{x[7]}}, x} + {{8{y[7]}}, y};
              sva_pkg::OpWaddu: wr16 = {8'd0, x} + {8'd0, y};
              sva_pkg::OpWsub:  wr16 = {{8{x[7]}}, x} - {{8{y[7]}}, y};
              default:          wr16 = {8'd0, x} - {8'd0, y};
            endcase
            if (!(unm2_q | m2_q[i])) wr16 = wo;
            full[16*i +: 16] = wr16;
          end
        end
      end
      2'd1: begin
        for (int unsigned i = 0; i < 4; i++) begin
          logic [31:0] p, wide, wo, wr32;
          logic [15:0] x, y, d, r16;
          wide = 32'd0;
          wo = 32'd0;
          wr32 = 32'd0;
          p = (i < 2) ? p16_lo[32*i +: 32] : p16_hi[32*(i-2) +: 32];
          x = a2_q[16*i +: 16];
          y = b2_q[16*i +: 16];
          d = o2_q[16*i +: 16];
          case (mode2_q)
            sva_pkg::OpMul:    r16 = p[15:0];
            sva_pkg::OpMulh, sva_pkg::OpMulhu, sva_pkg::OpMulhsu: r16 = p[31:16];
            sva_pkg::OpMacc:   r16 = d + p[15:0];
            sva_pkg::OpNmsac:  r16 = d - p[15:0];
            sva_pkg::OpMadd:   r16 = p[15:0] + x;
            default:           r16 = x - p[15:0];
          endcase
          if (!(unm2_q | m2_q[i])) r16 = d;
          mres[16*i +: 16] = r16;
          if (i < 2) begin
            wide = (i == 0) ? p16_lo[31:0] : p16_hi[31:0];
            wo = o2_q[32*i +: 32];
            case (mode2_q)
              sva_pkg::OpWmacc: wr32 = wo + wide;
              sva_pkg::OpWmul, sva_pkg::OpWmulu, sva_pkg::OpWmulsu: wr32 = wide;
              sva_pkg::OpWadd:  wr32 = {{16{x[15]}}, x} + {{16{y[15]}}, y};
              sva_pkg::OpWaddu: wr32 = {16'd0, x} + {16'd0, y};
              sva_pkg::OpWsub:  wr32 = {{16{x[15]}}, x} - {{16{y[15]}}, y};
              default:          wr32 = {16'd0, x} - {16'd0, y};
            endcase
            if (!(unm2_q | m2_q[i])) wr32 = wo;
            full[32*i +: 32] = wr32;
          end
        end
      end
      default: begin
        for (int unsigned i = 0; i < 2; i++) begin
          logic [63:0] p, wide, wr64;
          logic [31:0] x, y, d, r32;
          wide = 64'd0;
          wr64 = 64'd0;
          p = (i == 0) ? p32_lo : p32_hi;
          x = a2_q[32*i +: 32];
          y = b2_q[32*i +: 32];
          d = o2_q[32*i +: 32];
          case (mode2_q)
            sva_pkg::OpMul:    r32 = p[31:0];
            sva_pkg::OpMulh, sva_pkg::OpMulhu, sva_pkg::OpMulhsu: r32 = p[63:32];
            sva_pkg::OpMacc:   r32 = d + p[31:0];
            sva_pkg::OpNmsac:  r32 = d - p[31:0];
            sva_pkg::OpMadd:   r32 = p[31:0] + x;
            default:           r32 = x - p[31:0];
          endcase
          if (!(unm2_q | m2_q[i])) r32 = d;
          mres[32*i +: 32] = r32;
          if (i == 0) begin
            wide = p32_lo;
            case (mode2_q)
              sva_pkg::OpWmacc: wr64 = o2_q + wide;
              sva_pkg::OpWmul, sva_pkg::OpWmulu, sva_pkg::OpWmulsu: wr64 = wide;
              sva_pkg::OpWadd:  wr64 = {{32{x[31]}}, x} + {{32{y[31]}}, y};
              sva_pkg::OpWaddu: wr64 = {32'd0, x} + {32'd0, y};
              sva_pkg::OpWsub:  wr64 = {{32{x[31]}}, x} - {{32{y[31]}}, y};
              default:          wr64 = {32'd0, x} - {32'd0, y};
            endcase
            if (!(unm2_q | m2_q[0])) wr64 = o2_q;
            full = wr64;
          end
        end
      end
    endcase
  end

  logic [63:0] res3_d;
  always_comb begin
    if (!use_mul2_q) res3_d = r2_q;
    else if (mode2_q >= sva_pkg::OpWmacc) res3_d = full;
    else res3_d = mres;
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) res3_q <= res3_d;
  end

  assign done_o   = v3_q;
  assign result_o = res3_q;

endmodule

// ===== rtl/sva_checker.sv =====
`timescale 1ns / 1ps
module sva_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_i
);
  // each accepted beat returns a result beat, and none comes without one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_i) else $error("missing result beat");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> $past(start && !busy, 3)) else $error("spurious result beat");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("pipe stalled");
endmodule

bind simd_vector_alu sva_checker u_sva_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .done_i(done_o)
);
